// ===== rtl/stable_priority_queue_top_defines.svh =====
// assertion helpers for the priority queue
`ifndef STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH

// condition holds in the same cycle
`define SPQ_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("priority queue check failed");

// condition holds from the next cycle
`define SPQ_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> expr) \
      else $error("priority queue check failed");

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } error_type;

   typedef enum logic [1:0] {
      SLOT_HOLD,
      SLOT_TAKE_NEW,
      SLOT_FROM_PREV,
      SLOT_FROM_NEXT
   } slot_op_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] entry_tag;
      logic [3:0]  entry_priority;
   } req_type;

   typedef struct packed {
      logic        out_valid;
      logic [15:0] out_tag;
      logic [3:0]  out_priority;
      error_type   error_code;
      logic        is_empty;
      logic        is_full;
      logic [4:0]  entry_count;
   } rsp_type;

endpackage

// ===== rtl/spq_slot.sv =====
module spq_slot #(
   parameter int TAG_BITS  = 16,
   parameter int PRIO_BITS = 4
) (
   input  logic                 clock,
   input  spq_pkg::slot_op_type op,
   input  logic [TAG_BITS-1:0]  new_tag,
   input  logic [PRIO_BITS-1:0] new_prio,
   input  logic [TAG_BITS-1:0]  prev_tag,
   input  logic [PRIO_BITS-1:0] prev_prio,
   input  logic [TAG_BITS-1:0]  next_tag,
   input  logic [PRIO_BITS-1:0] next_prio,
   output logic [TAG_BITS-1:0]  tag,
   output logic [PRIO_BITS-1:0] prio,
   output logic                 lower
);

   logic [TAG_BITS-1:0]  tag_ff;
   logic [TAG_BITS-1:0]  tag_in;
   logic [PRIO_BITS-1:0] prio_ff;
   logic [PRIO_BITS-1:0] prio_in;

   always_comb begin
      unique case (op)
         spq_pkg::SLOT_HOLD: begin
            tag_in  = tag_ff;
            prio_in = prio_ff;
         end
         spq_pkg::SLOT_TAKE_NEW: begin
            tag_in  = new_tag;
            prio_in = new_prio;
         end
         spq_pkg::SLOT_FROM_PREV: begin
            tag_in  = prev_tag;
            prio_in = prev_prio;
         end
         spq_pkg::SLOT_FROM_NEXT: begin
            tag_in  = next_tag;
            prio_in = next_prio;
         end
         default: begin
            tag_in  = tag_ff;
            prio_in = prio_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      prio_ff <= prio_in;
   end

   assign tag   = tag_ff;
   assign prio  = prio_ff;
   assign lower = prio_ff < new_prio;

endmodule

// ===== rtl/stable_priority_queue_top.sv =====
// channel    ports                          handshake
// request    start, busy, req_data          taken when start high and busy low
// response   rsp_strobe, rsp_data           one cycle wide, cannot be held off
//
// one request per cycle; busy stays low
// response strobes once the request has passed through req_valid_ff and rsp_strobe_ff
// insert and remove finish in one pass over the slot row
// synchronous reset empties the queue; slot contents stay as they are

`include "stable_priority_queue_top_defines.svh"

module stable_priority_queue_top #(
   parameter int DEPTH     = 16,
   parameter int TAG_BITS  = 16,
   parameter int PRIO_BITS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output spq_pkg::rsp_type rsp_data
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic                            req_valid_ff;
   spq_pkg::req_type                req_ff;
   logic [CNT_BITS-1:0]             count_ff;
   logic [CNT_BITS-1:0]             count_in;
   logic                            rsp_strobe_ff;
   spq_pkg::rsp_type                rsp_ff;
   spq_pkg::rsp_type                rsp_in;

   logic [TAG_BITS-1:0]             new_tag;
   logic [PRIO_BITS-1:0]            new_prio;
   logic [DEPTH-1:0][TAG_BITS-1:0]  slot_tag;
   logic [DEPTH-1:0][PRIO_BITS-1:0] slot_prio;
   logic [DEPTH-1:0]                slot_lower;
   logic [DEPTH-1:0]                goes_below;
   spq_pkg::slot_op_type            slot_op [DEPTH];

   logic                            queue_full;
   logic                            queue_empty;
   logic                            do_insert;
   logic                            do_remove;

   assign busy     = 1'b0;
   assign new_tag  = TAG_BITS'(req_ff.entry_tag);
   assign new_prio = PRIO_BITS'(req_ff.entry_priority);

   assign queue_full  = count_ff == CNT_BITS'(DEPTH);
   assign queue_empty = count_ff == '0;
   assign do_insert   = req_valid_ff && (req_ff.kind == spq_pkg::KIND_INSERT) && !queue_full;
   assign do_remove   = req_valid_ff && (req_ff.kind == spq_pkg::KIND_REMOVE) && !queue_empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      logic [TAG_BITS-1:0]  prev_tag;
      logic [PRIO_BITS-1:0] prev_prio;
      logic [TAG_BITS-1:0]  next_tag;
      logic [PRIO_BITS-1:0] next_prio;
      logic                 above_below;

      assign goes_below[i] = (CNT_BITS'(i) >= count_ff) || slot_lower[i];

      if (i == 0) begin : g_first
         assign prev_tag    = new_tag;
         assign prev_prio   = new_prio;
         assign above_below = 1'b0;
      end else begin : g_rest
         assign prev_tag    = slot_tag[i-1];
         assign prev_prio   = slot_prio[i-1];
         assign above_below = goes_below[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_tag  = slot_tag[i];
         assign next_prio = slot_prio[i];
      end else begin : g_inner
         assign next_tag  = slot_tag[i+1];
         assign next_prio = slot_prio[i+1];
      end

      always_comb begin
         priority if (do_insert && goes_below[i]) begin
            slot_op[i] = above_below ? spq_pkg::SLOT_FROM_PREV : spq_pkg::SLOT_TAKE_NEW;
         end else if (do_remove && (i != DEPTH - 1)) begin
            slot_op[i] = spq_pkg::SLOT_FROM_NEXT;
         end else begin
            slot_op[i] = spq_pkg::SLOT_HOLD;
         end
      end

      spq_slot #(
         .TAG_BITS  (TAG_BITS),
         .PRIO_BITS (PRIO_BITS)
      ) u_slot (
         .clock     (clock),
         .op        (slot_op[i]),
         .new_tag   (new_tag),
         .new_prio  (new_prio),
         .prev_tag  (prev_tag),
         .prev_prio (prev_prio),
         .next_tag  (next_tag),
         .next_prio (next_prio),
         .tag       (slot_tag[i]),
         .prio      (slot_prio[i]),
         .lower     (slot_lower[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (do_remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_in.out_valid    = do_remove;
      rsp_in.out_tag      = do_remove ? 16'(slot_tag[0]) : '0;
      rsp_in.out_priority = do_remove ? 4'(slot_prio[0]) : '0;
      rsp_in.error_code   = spq_pkg::ERR_OK;
      if ((req_ff.kind == spq_pkg::KIND_INSERT) && queue_full) begin
         rsp_in.error_code = spq_pkg::ERR_FULL;
      end else if ((req_ff.kind == spq_pkg::KIND_REMOVE) && queue_empty) begin
         rsp_in.error_code = spq_pkg::ERR_EMPTY;
      end
      rsp_in.is_empty     = count_in == '0;
      rsp_in.is_full      = count_in == CNT_BITS'(DEPTH);
      rsp_in.entry_count  = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         req_valid_ff  <= start && !busy;
         count_ff      <= count_in;
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `SPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(DEPTH))
   `SPQ_ASSERT_NEXT(a_rsp_follows, clock, reset, start && !busy, ##1 rsp_strobe_ff)
   `SPQ_ASSERT_NOW(a_removed_ok, clock, reset, rsp_strobe_ff && rsp_ff.out_valid,
                   rsp_ff.error_code == spq_pkg::ERR_OK)
   `SPQ_ASSERT_NEXT(a_insert_count, clock, reset, do_insert,
                    count_ff == CNT_BITS'($past(count_ff) + 1'b1))
   `SPQ_ASSERT_NOW(a_head_order, clock, reset, count_ff >= CNT_BITS'(2),
                   slot_prio[0] >= slot_prio[1])

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int QUEUE_DEPTH = 16;
   localparam int RANDOM_ITEMS = 528;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   spq_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   spq_pkg::rsp_type rsp_data;

   // reference copy of the queue, head at index 0
   logic [15:0] queue_tags [QUEUE_DEPTH];
   logic [3:0]  queue_prios [QUEUE_DEPTH];
   int          queue_count = 0;

   spq_pkg::rsp_type pending_rsps [$];
   spq_pkg::rsp_type want_rsp;

   int failures = 0;
   int n_checked = 0;
   int n_inserts = 0;
   int n_removes = 0;
   int n_full_drops = 0;
   int n_empty_errors = 0;
   int n_requests = 0;
   bit gaps_on = 1'b1;

   stable_priority_queue_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic spq_pkg::rsp_type predict_queue_step(spq_pkg::req_type r);
      spq_pkg::rsp_type res;
      int               pos;
      bit               found;
      res = '0;
      res.error_code = spq_pkg::ERR_OK;
      if (r.kind == spq_pkg::KIND_INSERT) begin
         if (queue_count >= QUEUE_DEPTH) begin
            res.error_code = spq_pkg::ERR_FULL;
            n_full_drops++;
         end else begin
            pos = queue_count;
            found = 1'b0;
            for (int i = 0; i < queue_count; i++) begin
               if (!found && queue_prios[i] < r.entry_priority) begin
                  pos = i;
                  found = 1'b1;
               end
            end
            for (int i = queue_count; i > pos; i--) begin
               queue_tags[i] = queue_tags[i-1];
               queue_prios[i] = queue_prios[i-1];
            end
            queue_tags[pos] = r.entry_tag;
            queue_prios[pos] = r.entry_priority;
            queue_count++;
            n_inserts++;
         end
      end else begin
         if (queue_count == 0) begin
            res.error_code = spq_pkg::ERR_EMPTY;
            n_empty_errors++;
         end else begin
            res.out_valid = 1'b1;
            res.out_tag = queue_tags[0];
            res.out_priority = queue_prios[0];
            for (int i = 1; i < queue_count; i++) begin
               queue_tags[i-1] = queue_tags[i];
               queue_prios[i-1] = queue_prios[i];
            end
            queue_count--;
            n_removes++;
         end
      end
      res.is_empty = (queue_count == 0);
      res.is_full = (queue_count >= QUEUE_DEPTH);
      res.entry_count = 5'(queue_count);
      return res;
   endfunction

   task automatic report_failure(string msg);
      failures++;
      if (failures <= 10) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
         report_failure($sformatf("%s expected %0h got %0h", name, want_v, got_v));
      end
   endtask

   // prediction on each taken request, then compare any result strobed this cycle
   always @(posedge clock) begin
      if (!reset && start === 1'b1 && busy === 1'b0) begin
         pending_rsps.push_back(predict_queue_step(req_data));
         n_requests++;
      end
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsps.size() == 0) begin
            report_failure("result with no request pending");
         end else begin
            want_rsp = pending_rsps.pop_front();
            check_field("out_valid", 32'(want_rsp.out_valid), 32'(rsp_data.out_valid));
            check_field("out_tag", 32'(want_rsp.out_tag), 32'(rsp_data.out_tag));
            check_field("out_priority", 32'(want_rsp.out_priority),
                        32'(rsp_data.out_priority));
            check_field("error_code", 32'(want_rsp.error_code), 32'(rsp_data.error_code));
            check_field("is_empty", 32'(want_rsp.is_empty), 32'(rsp_data.is_empty));
            check_field("is_full", 32'(want_rsp.is_full), 32'(rsp_data.is_full));
            check_field("entry_count", 32'(want_rsp.entry_count),
                        32'(rsp_data.entry_count));
            n_checked++;
         end
      end
   end

   task automatic maybe_idle();
      if (gaps_on && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_request(spq_pkg::kind_type k, logic [15:0] tag, logic [3:0] prio);
      spq_pkg::req_type r;
      maybe_idle();
      r.kind = k;
      r.entry_tag = tag;
      r.entry_priority = prio;
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic test_remove_from_empty();
      send_request(spq_pkg::KIND_REMOVE, 16'hffff, 4'hf);
   endtask

   // extremes of tag and priority, fifo order among equal priorities
   task automatic test_insert_extremes();
      send_request(spq_pkg::KIND_INSERT, 16'h0000, 4'h0);
      send_request(spq_pkg::KIND_INSERT, 16'hffff, 4'hf);
      send_request(spq_pkg::KIND_INSERT, 16'ha5a5, 4'hf);
      send_request(spq_pkg::KIND_INSERT, 16'h5a5a, 4'h0);
      send_request(spq_pkg::KIND_INSERT, 16'h1234, 4'h7);
      send_request(spq_pkg::KIND_REMOVE, 16'h0000, 4'h0);
      send_request(spq_pkg::KIND_INSERT, 16'h8001, 4'hf);
   endtask

   // fill up, insert while full, remove at full, refill
   task automatic test_fill_and_overflow();
      int n;
      n = 0;
      while (queue_count < QUEUE_DEPTH && n < QUEUE_DEPTH) begin
         send_request(spq_pkg::KIND_INSERT, 16'(16'h0100 + n), 4'((n * 5) % 3 + 6));
         n++;
      end
      send_request(spq_pkg::KIND_INSERT, 16'hdead, 4'hf);
      send_request(spq_pkg::KIND_REMOVE, 16'hffff, 4'hf);
      send_request(spq_pkg::KIND_INSERT, 16'hbeef, 4'h7);
   endtask

   // bursts leaning toward filling, draining, or balanced
   task automatic test_random_traffic();
      int                remove_pct;
      spq_pkg::kind_type k;
      logic [3:0]        prio;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         gaps_on = !(i >= 150 && i < 300);
         unique case ((i / 40) % 3)
            0: remove_pct = 25;
            1: remove_pct = 75;
            default: remove_pct = 50;
         endcase
         k = ($urandom_range(0, 99) < remove_pct) ? spq_pkg::KIND_REMOVE
                                                  : spq_pkg::KIND_INSERT;
         prio = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(6, 8));
         send_request(k, 16'($urandom_range(0, 65535)), prio);
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      int wait_cycles;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_remove_from_empty();
      test_insert_extremes();
      test_fill_and_overflow();
      test_random_traffic();
      start <= 1'b0;
      wait_cycles = 0;
      while (pending_rsps.size() != 0 && wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (5) @(posedge clock);
      if (pending_rsps.size() != 0) begin
         report_failure($sformatf("%0d results never arrived", pending_rsps.size()));
      end
      $display("%0d requests sent, %0d results checked, %0d failures", n_requests,
               n_checked, failures);
      $display("%0d inserts, %0d removes, %0d dropped when full, %0d removes when empty",
               n_inserts, n_removes, n_full_drops, n_empty_errors);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
